// ===== hdl/dme_pkg.sv =====
// Shared widths, constants and the controller-to-datapath command bundle
// for the data rate mantissa/exponent calculator. No dependencies.
`timescale 1ns / 1ps

package dme_pkg;

  localparam int unsigned RateW    = 20;              // requested data rate
  localparam int unsigned ClkW     = 26;              // reference clock in Hz
  localparam int unsigned DivW     = ClkW - 5;        // clock >> 5
  localparam int unsigned ManW     = 8;
  localparam int unsigned ExpW     = 4;
  localparam int unsigned ShW      = 5;               // shift amounts 8..23
  localparam int unsigned MaxShift = 23;
  localparam int unsigned DvdW     = RateW + MaxShift; // rate << 23 at most
  localparam int unsigned ProdW    = DivW + ManW + 1;  // (256 + m) * div
  localparam int unsigned CntW     = $clog2(DvdW);
  localparam int unsigned NumCand  = 3;
  localparam int unsigned CandW    = 2;

  localparam logic [ClkW-1:0] ClkReset = ClkW'(26000000);

  typedef struct packed {
    logic             load;      // capture the input rate
    logic             exp_en;    // pick the exponent
    logic             div_init;  // load dividend, clear remainder
    logic             div_step;  // one restoring division step
    logic             mul_en;    // form the candidate and its product
    logic             score_en;  // score the candidate, keep the best
    logic             out_load;  // move the result to the output register
    logic [CandW-1:0] cand;      // candidate index 0..2
  } dme_cmd_t;

endpackage

// ===== hdl/dme_ctrl.sv =====
// Sequencer for the rate calculator: handshakes, step counting and the
// command bundle to the datapath. Depends on dme_pkg.
`timescale 1ns / 1ps

module dme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dme_pkg::dme_cmd_t cmd_o
);
  import dme_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StExp   = 7'b0000010,
    StDivI  = 7'b0000100,
    StDiv   = 7'b0001000,
    StMul   = 7'b0010000,
    StScore = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CandW-1:0] cand_q, cand_d;
  logic             valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cand_d  = cand_q;
    cmd_o   = '0;
    cmd_o.cand = cand_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExp;
        end
      end
      StExp: begin
        cmd_o.exp_en = 1'b1;
        state_d      = StDivI;
      end
      StDivI: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DvdW - 1)) begin
          cand_d  = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StScore;
      end
      StScore: begin
        cmd_o.score_en = 1'b1;
        cand_d         = cand_q + 1'b1;
        state_d        = (cand_q == CandW'(NumCand - 1)) ? StOut : StMul;
      end
      StOut: begin
        // wait for the output register to free up
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_o.out_load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      cand_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cand_q  <= cand_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = valid_q;

endmodule

// ===== hdl/dme_dpath.sv =====
// Datapath of the rate calculator: clock register, exponent pick,
// bit-serial divider, candidate multiply and scoring. Depends on dme_pkg.
`timescale 1ns / 1ps

module dme_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dme_pkg::dme_cmd_t          cmd_i,
  input  logic                       cfg_we_i,
  input  logic [dme_pkg::ClkW-1:0]   cfg_wdata_i,
  input  logic [dme_pkg::RateW-1:0]  rate_i,
  output logic [dme_pkg::ManW-1:0]   man_o,
  output logic [dme_pkg::ExpW-1:0]   exp_o
);
  import dme_pkg::*;

  logic [ClkW-1:0]  clk_hz_q;
  logic [RateW-1:0] rate_q;
  logic [ExpW-1:0]  exp_q, exp_d;
  logic [DvdW-1:0]  rq_q;      // dividend shifting out, quotient shifting in
  logic [DivW-1:0]  rem_q;
  logic [ManW-1:0]  m_q, m_d, base;
  logic [ProdW-1:0] prod_q;
  logic [ManW-1:0]  best_man_q;
  logic [ProdW-1:0] best_score_q;
  logic [ManW-1:0]  out_man_q;
  logic [ExpW-1:0]  out_exp_q;

  logic [DivW-1:0]  div;
  logic [ShW-1:0]   sh;
  logic [DivW:0]    trial;
  logic             ge;
  logic [ProdW-1:0] approx, rate_w, score;

  assign div = clk_hz_q[ClkW-1:5];
  assign sh  = ShW'(MaxShift) - ShW'(exp_q);

  // largest exponent whose threshold the rate reaches
  always_comb begin
    exp_d = '0;
    for (int i = 1; i <= 15; i++) begin
      if ({{(ClkW-RateW){1'b0}}, rate_q} >= (clk_hz_q >> (20 - i))) begin
        exp_d = ExpW'(i);
      end
    end
  end

  assign trial = {rem_q, rq_q[DvdW-1]};
  assign ge    = (trial >= {1'b0, div});

  // quotient minus 256 keeps the low byte; below 256 (or zero divisor) clamps
  assign base = ((div != '0) && (rq_q[DvdW-1:ManW] != '0)) ? rq_q[ManW-1:0] : '0;
  assign m_d  = base + ManW'(cmd_i.cand) + {ManW{1'b1}};

  assign rate_w = ProdW'(rate_q);
  assign approx = prod_q >> sh;
  assign score  = (rate_w >= approx) ? (rate_w - approx) : (approx - rate_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkReset;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rate_q <= rate_i;
    end
    if (cmd_i.exp_en) begin
      exp_q <= exp_d;
    end
    if (cmd_i.div_init) begin
      rq_q  <= DvdW'(rate_q) << sh;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? DivW'(trial - {1'b0, div}) : trial[DivW-1:0];
      rq_q  <= {rq_q[DvdW-2:0], ge};
    end
    if (cmd_i.mul_en) begin
      m_q    <= m_d;
      prod_q <= ProdW'({1'b1, m_d}) * ProdW'(div);
    end
    if (cmd_i.score_en) begin
      if ((cmd_i.cand == '0) || (score < best_score_q)) begin
        best_score_q <= score;
        best_man_q   <= m_q;
      end
    end
    if (cmd_i.out_load) begin
      out_man_q <= best_man_q;
      out_exp_q <= exp_q;
    end
  end

  assign man_o = out_man_q;
  assign exp_o = out_exp_q;

endmodule

// ===== hdl/datarate_mantissa_exponent.sv =====
// Top level of the data rate mantissa/exponent calculator: stream ports,
// controller and datapath. Depends on dme_pkg, dme_ctrl and dme_dpath.
`timescale 1ns / 1ps

// Converts a requested data rate (bits/s) into the radio's 8-bit mantissa
// and 4-bit exponent for the reference clock held in the configuration
// register (reset value 26 MHz; write it only while no request is in
// flight). Each request yields one result. A request passes through the exponent
// pick, the 43-step restoring divider, which retires one quotient bit per cycle,
// and the three candidate mantissas through one shared multiplier; no new request
// is taken until its result has moved to the output register. The output register
// holds a finished result while the next request is accepted.

module datarate_mantissa_exponent (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: reference_clock_hz
  input  logic                      cfg_we_i,
  input  logic [dme_pkg::ClkW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [23:0]               s_axis_tdata_i,  // [19:0] data_rate, [23:20] zero
  // result stream
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [15:0]               m_axis_tdata_o   // [7:0] rate_mantissa,
                                                     // [11:8] rate_exponent, [15:12] zero
);
  import dme_pkg::*;

  dme_cmd_t        cmd;
  logic [ManW-1:0] man;
  logic [ExpW-1:0] expo;

  dme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  dme_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rate_i      (s_axis_tdata_i[RateW-1:0]),
    .man_o       (man),
    .exp_o       (expo)
  );

  assign m_axis_tdata_o = {4'b0000, expo, man};

  // a request in work blocks further input transfers
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while a request is in work");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("pending result overwritten");

  // a loaded result is offered in the following cycle
  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o)
    else $error("result loaded but not offered");

  // datapath steps are never commanded while idle and accepting
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !(cmd.div_step || cmd.mul_en || cmd.score_en))
    else $error("datapath active while idle");

endmodule
